FILE: design/mshp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mshp_pkg;

   typedef logic [1:0] cmd_type;
   typedef logic [1:0] status_type;

   localparam cmd_type CMD_ALLOC   = 2'd0;
   localparam cmd_type CMD_PUSH    = 2'd1;
   localparam cmd_type CMD_POP     = 2'd2;
   localparam cmd_type CMD_COLLECT = 2'd3;

   localparam status_type ST_OK         = 2'd0;
   localparam status_type ST_HEAP_FULL  = 2'd1;
   localparam status_type ST_ROOT_FULL  = 2'd2;
   localparam status_type ST_ROOT_EMPTY = 2'd3;

endpackage

`default_nettype wire

FILE: design/mark_sweep_pair_heap.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Handshake
// request   req_cmd, req_first_ref, req_second_ref  start high while busy is low
// response  rsp_result_ref, rsp_status              rsp_valid high for one cycle
//
// After reset the heap is initialised by a pass over every cell with busy high.
// Push and rejected commands complete in the idle state; allocate and pop complete
// after the registered read of the link or root memory. Collect checks each root,
// skips it if out of range or already marked, else marks it and traces every cell
// reachable from it; it then sweeps every heap cell and closes the free list.
// Each response beat appears the cycle after the command completes; the receiver
// cannot stall it, and the next command may be taken in that same cycle.

module mark_sweep_pair_heap #(
   parameter int HEAP_CELLS  = 256,
   parameter int STACK_DEPTH = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output      logic                              busy,
   input  wire mshp_pkg::cmd_type                 req_cmd,
   input  wire logic [$clog2(HEAP_CELLS+1)-1:0]   req_first_ref,
   input  wire logic [$clog2(HEAP_CELLS+1)-1:0]   req_second_ref,
   output      logic                              rsp_valid,
   output      logic [$clog2(HEAP_CELLS+1)-1:0]   rsp_result_ref,
   output      mshp_pkg::status_type              rsp_status
);

   import mshp_pkg::*;

   localparam int RW  = $clog2(HEAP_CELLS+1);
   localparam int AW  = $clog2(HEAP_CELLS);
   localparam int SW  = $clog2(STACK_DEPTH+1);
   localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [RW-1:0] NULL_REF = RW'(HEAP_CELLS);
   localparam logic [RW-1:0] LAST_CELL = RW'(HEAP_CELLS-1);
   localparam logic [SW-1:0] STACK_FULL = SW'(STACK_DEPTH);

   localparam logic [3:0] S_INIT     = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_ALLOC    = 4'd2;
   localparam logic [3:0] S_POP      = 4'd3;
   localparam logic [3:0] S_MK_NEXT  = 4'd4;
   localparam logic [3:0] S_MK_ROOT  = 4'd5;
   localparam logic [3:0] S_MK_RCHK  = 4'd6;
   localparam logic [3:0] S_TR_POP   = 4'd7;
   localparam logic [3:0] S_TR_CELL  = 4'd8;
   localparam logic [3:0] S_TR_KIDS  = 4'd9;
   localparam logic [3:0] S_TR_K0    = 4'd10;
   localparam logic [3:0] S_TR_K1R   = 4'd11;
   localparam logic [3:0] S_TR_K1    = 4'd12;
   localparam logic [3:0] S_SW_RD    = 4'd13;
   localparam logic [3:0] S_SW_CHK   = 4'd14;
   localparam logic [3:0] S_SW_END   = 4'd15;

   logic [3:0]    state_ff, state_in;
   logic [RW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] free_head_ff, free_head_in;
   logic [SW-1:0] root_count_ff, root_count_in;
   logic [SW-1:0] root_idx_ff, root_idx_in;
   logic [RW-1:0] depth_ff, depth_in;
   logic [RW-1:0] tail_ff, tail_in;
   logic [RW-1:0] cell_ff, cell_in;
   logic [RW-1:0] kid0_ff, kid0_in;
   logic [RW-1:0] kid1_ff, kid1_in;
   logic [RW-1:0] first_ff, first_in;
   logic [RW-1:0] second_ff, second_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0] rsp_ref_ff, rsp_ref_in;
   status_type    rsp_status_ff, rsp_status_in;

   logic          left_we, right_we, mark_we, root_we, trace_we;
   logic [AW-1:0] left_wa, right_wa, mark_wa, trace_wa, left_ra, mark_ra, trace_ra;
   logic [SAW-1:0] root_wa, root_ra;
   logic [RW-1:0] left_wd, right_wd, root_wd, trace_wd;
   logic          mark_wd;
   logic [RW-1:0] left_rd, right_rd, root_rd, trace_rd;
   logic          mark_rd;

   mshp_ram #(.WIDTH(RW), .DEPTH(HEAP_CELLS), .AW(AW)) u_left (
      .clock(clock), .wr_en(left_we), .wr_addr(left_wa), .wr_data(left_wd),
      .rd_addr(left_ra), .rd_data(left_rd));
   mshp_ram #(.WIDTH(RW), .DEPTH(HEAP_CELLS), .AW(AW)) u_right (
      .clock(clock), .wr_en(right_we), .wr_addr(right_wa), .wr_data(right_wd),
      .rd_addr(left_ra), .rd_data(right_rd));
   mshp_ram #(.WIDTH(1), .DEPTH(HEAP_CELLS), .AW(AW)) u_mark (
      .clock(clock), .wr_en(mark_we), .wr_addr(mark_wa), .wr_data(mark_wd),
      .rd_addr(mark_ra), .rd_data(mark_rd));
   mshp_ram #(.WIDTH(RW), .DEPTH(STACK_DEPTH), .AW(SAW)) u_root (
      .clock(clock), .wr_en(root_we), .wr_addr(root_wa), .wr_data(root_wd),
      .rd_addr(root_ra), .rd_data(root_rd));
   mshp_ram #(.WIDTH(RW), .DEPTH(HEAP_CELLS), .AW(AW)) u_trace (
      .clock(clock), .wr_en(trace_we), .wr_addr(trace_wa), .wr_data(trace_wd),
      .rd_addr(trace_ra), .rd_data(trace_rd));

   function automatic logic [RW-1:0] clamp_ref(input logic [RW-1:0] r);
      return (r < NULL_REF) ? r : NULL_REF;
   endfunction

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      free_head_in  = free_head_ff;
      root_count_in = root_count_ff;
      root_idx_in   = root_idx_ff;
      depth_in      = depth_ff;
      tail_in       = tail_ff;
      cell_in       = cell_ff;
      kid0_in       = kid0_ff;
      kid1_in       = kid1_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      rsp_valid_in  = 1'b0;
      rsp_ref_in    = NULL_REF;
      rsp_status_in = ST_OK;
      left_we  = 1'b0;
      right_we = 1'b0;
      mark_we  = 1'b0;
      root_we  = 1'b0;
      trace_we = 1'b0;
      left_wa  = cell_ff[AW-1:0];
      right_wa = cell_ff[AW-1:0];
      mark_wa  = cell_ff[AW-1:0];
      root_wa  = root_count_ff[SAW-1:0];
      trace_wa = depth_ff[AW-1:0];
      left_wd  = NULL_REF;
      right_wd = NULL_REF;
      mark_wd  = 1'b0;
      root_wd  = req_first_ref;
      trace_wd = cell_ff;
      left_ra  = free_head_ff[AW-1:0];
      mark_ra  = cell_ff[AW-1:0];
      root_ra  = root_idx_ff[SAW-1:0];
      trace_ra = depth_ff[AW-1:0];

      unique case (state_ff)
         S_INIT: begin
            left_we  = 1'b1;
            right_we = 1'b1;
            mark_we  = 1'b1;
            left_wa  = cnt_ff[AW-1:0];
            right_wa = cnt_ff[AW-1:0];
            mark_wa  = cnt_ff[AW-1:0];
            right_wd = cnt_ff + RW'(1);
            cnt_in   = cnt_ff + RW'(1);
            if (cnt_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            root_ra = SAW'(root_count_ff - SW'(1));
            if (start) begin
               first_in  = req_first_ref;
               second_in = req_second_ref;
               cell_in   = free_head_ff;
               unique case (req_cmd)
                  CMD_ALLOC: begin
                     if (free_head_ff == NULL_REF) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_HEAP_FULL;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  CMD_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (root_count_ff >= STACK_FULL) begin
                        rsp_status_in = ST_ROOT_FULL;
                     end else begin
                        root_we       = 1'b1;
                        root_count_in = root_count_ff + SW'(1);
                     end
                  end
                  CMD_POP: begin
                     if (root_count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_ROOT_EMPTY;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  default: begin
                     root_idx_in = '0;
                     state_in    = S_MK_NEXT;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            free_head_in = right_rd;
            left_we      = 1'b1;
            right_we     = 1'b1;
            mark_we      = 1'b1;
            left_wd      = clamp_ref(first_ff);
            right_wd     = clamp_ref(second_ff);
            rsp_valid_in = 1'b1;
            rsp_ref_in   = cell_ff;
            state_in     = S_IDLE;
         end
         S_POP: begin
            root_count_in = root_count_ff - SW'(1);
            rsp_valid_in  = 1'b1;
            rsp_ref_in    = root_rd;
            state_in      = S_IDLE;
         end
         S_MK_NEXT: begin
            if (root_idx_ff == root_count_ff) begin
               cnt_in       = '0;
               tail_in      = NULL_REF;
               free_head_in = NULL_REF;
               state_in     = S_SW_RD;
            end else begin
               root_idx_in = root_idx_ff + SW'(1);
               state_in    = S_MK_ROOT;
            end
         end
         S_MK_ROOT: begin
            cell_in = root_rd;
            mark_ra = root_rd[AW-1:0];
            if (root_rd >= NULL_REF) begin
               state_in = S_MK_NEXT;
            end else begin
               state_in = S_MK_RCHK;
            end
         end
         S_MK_RCHK: begin
            if (mark_rd) begin
               state_in = S_MK_NEXT;
            end else begin
               mark_we  = 1'b1;
               mark_wd  = 1'b1;
               trace_we = 1'b1;
               trace_wa = '0;
               depth_in = RW'(1);
               state_in = S_TR_POP;
            end
         end
         S_TR_POP: begin
            trace_ra = AW'(depth_ff - RW'(1));
            if (depth_ff == '0) begin
               state_in = S_MK_NEXT;
            end else begin
               depth_in = depth_ff - RW'(1);
               state_in = S_TR_CELL;
            end
         end
         S_TR_CELL: begin
            left_ra  = trace_rd[AW-1:0];
            state_in = S_TR_KIDS;
         end
         S_TR_KIDS: begin
            kid0_in  = left_rd;
            kid1_in  = right_rd;
            mark_ra  = left_rd[AW-1:0];
            state_in = S_TR_K0;
         end
         S_TR_K0: begin
            if (kid0_ff < NULL_REF && !mark_rd) begin
               mark_we  = 1'b1;
               mark_wd  = 1'b1;
               mark_wa  = kid0_ff[AW-1:0];
               trace_we = 1'b1;
               trace_wd = kid0_ff;
               depth_in = depth_ff + RW'(1);
            end
            state_in = S_TR_K1R;
         end
         S_TR_K1R: begin
            mark_ra  = kid1_ff[AW-1:0];
            state_in = S_TR_K1;
         end
         S_TR_K1: begin
            if (kid1_ff < NULL_REF && !mark_rd) begin
               mark_we  = 1'b1;
               mark_wd  = 1'b1;
               mark_wa  = kid1_ff[AW-1:0];
               trace_we = 1'b1;
               trace_wd = kid1_ff;
               depth_in = depth_ff + RW'(1);
            end
            state_in = S_TR_POP;
         end
         S_SW_RD: begin
            mark_ra  = cnt_ff[AW-1:0];
            state_in = S_SW_CHK;
         end
         S_SW_CHK: begin
            if (mark_rd) begin
               mark_we = 1'b1;
               mark_wa = cnt_ff[AW-1:0];
            end else begin
               if (tail_ff == NULL_REF) begin
                  free_head_in = cnt_ff;
               end else begin
                  right_we = 1'b1;
                  right_wa = tail_ff[AW-1:0];
                  right_wd = cnt_ff;
               end
               tail_in = cnt_ff;
            end
            cnt_in = cnt_ff + RW'(1);
            if (cnt_ff == LAST_CELL) begin
               state_in = S_SW_END;
            end else begin
               state_in = S_SW_RD;
            end
         end
         S_SW_END: begin
            if (tail_ff != NULL_REF) begin
               right_we = 1'b1;
               right_wa = tail_ff[AW-1:0];
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cnt_ff        <= '0;
         free_head_ff  <= '0;
         root_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         free_head_ff  <= free_head_in;
         root_count_ff <= root_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      root_idx_ff   <= root_idx_in;
      depth_ff      <= depth_in;
      tail_ff       <= tail_in;
      cell_ff       <= cell_in;
      kid0_ff       <= kid0_in;
      kid1_ff       <= kid1_in;
      first_ff      <= first_in;
      second_ff     <= second_in;
      rsp_ref_ff    <= rsp_ref_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_ref = rsp_ref_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

FILE: design/mshp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module mshp_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: tb/mark_sweep_pair_heap_test.sv
`timescale 1ns / 1ps

module mark_sweep_pair_heap_test;
   import mshp_pkg::*;

   localparam int HEAP_CELLS  = 256;
   localparam int STACK_DEPTH = 64;
   localparam int REF_W       = 9;
   localparam logic [REF_W-1:0] NULL_REF = REF_W'(HEAP_CELLS);
   localparam int CYCLE_LIMIT = 2_000_000;

   typedef struct packed {
      cmd_type          cmd;
      logic [REF_W-1:0] first_ref;
      logic [REF_W-1:0] second_ref;
   } heap_cmd_t;

   typedef struct packed {
      logic [REF_W-1:0] result_ref;
      status_type       status;
   } heap_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   cmd_type req_cmd = CMD_PUSH;
   logic [REF_W-1:0] req_first_ref = '0;
   logic [REF_W-1:0] req_second_ref = '0;
   logic rsp_valid;
   logic [REF_W-1:0] rsp_result_ref;
   status_type rsp_status;

   mark_sweep_pair_heap #(.HEAP_CELLS(HEAP_CELLS), .STACK_DEPTH(STACK_DEPTH)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_first_ref(req_first_ref),
      .req_second_ref(req_second_ref), .rsp_valid(rsp_valid),
      .rsp_result_ref(rsp_result_ref), .rsp_status(rsp_status)
   );

   always #5 clock = ~clock;

   // Shadow heap state.
   logic [REF_W-1:0] left_link [HEAP_CELLS];
   logic [REF_W-1:0] right_link[HEAP_CELLS];
   bit               marked    [HEAP_CELLS];
   logic [REF_W-1:0] free_list_head;
   logic [REF_W-1:0] roots     [STACK_DEPTH];
   int               root_depth;

   heap_cmd_t pending_cmds[$];
   heap_rsp_t expected_rsps[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  stimulus_done = 1'b0;
   bit  hold_until_drained = 1'b0;
   int  burst_left = 0;
   int  gap_left = 0;

   function automatic logic [REF_W-1:0] to_cell_ref(logic [REF_W-1:0] r);
      return (r < HEAP_CELLS) ? r : NULL_REF;
   endfunction

   task automatic reset_heap_model();
      for (int i = 0; i < HEAP_CELLS; i++) begin
         left_link[i] = NULL_REF;
         right_link[i] = REF_W'(i + 1);
         marked[i] = 1'b0;
      end
      free_list_head = '0;
      root_depth = 0;
   endtask

   function automatic void mark_from(logic [REF_W-1:0] root);
      logic [REF_W-1:0] trace[$];
      logic [REF_W-1:0] node;
      logic [REF_W-1:0] kid;
      if (root >= HEAP_CELLS || marked[root]) return;
      marked[root] = 1'b1;
      trace.push_back(root);
      while (trace.size() > 0) begin
         node = trace.pop_back();
         for (int k = 0; k < 2; k++) begin
            kid = (k == 0) ? left_link[node] : right_link[node];
            if (kid < HEAP_CELLS && !marked[kid]) begin
               marked[kid] = 1'b1;
               trace.push_back(kid);
            end
         end
      end
   endfunction

   function automatic void collect_garbage();
      logic [REF_W-1:0] tail;
      tail = NULL_REF;
      for (int i = 0; i < root_depth; i++) mark_from(roots[i]);
      free_list_head = NULL_REF;
      for (int i = 0; i < HEAP_CELLS; i++) begin
         if (marked[i]) begin
            marked[i] = 1'b0;
         end else begin
            if (tail == NULL_REF) free_list_head = REF_W'(i);
            else right_link[tail] = REF_W'(i);
            tail = REF_W'(i);
         end
      end
      if (tail != NULL_REF) right_link[tail] = NULL_REF;
   endfunction

   function automatic heap_rsp_t apply_heap_cmd(heap_cmd_t c);
      heap_rsp_t r;
      logic [REF_W-1:0] slot;
      r.result_ref = NULL_REF;
      r.status = ST_OK;
      case (c.cmd)
         CMD_ALLOC: begin
            if (free_list_head >= HEAP_CELLS) begin
               r.status = ST_HEAP_FULL;
            end else begin
               slot = free_list_head;
               free_list_head = right_link[slot];
               left_link[slot] = to_cell_ref(c.first_ref);
               right_link[slot] = to_cell_ref(c.second_ref);
               marked[slot] = 1'b0;
               r.result_ref = slot;
            end
         end
         CMD_PUSH: begin
            if (root_depth >= STACK_DEPTH) begin
               r.status = ST_ROOT_FULL;
            end else begin
               roots[root_depth] = c.first_ref;
               root_depth++;
            end
         end
         CMD_POP: begin
            if (root_depth == 0) begin
               r.status = ST_ROOT_EMPTY;
            end else begin
               root_depth--;
               r.result_ref = roots[root_depth];
            end
         end
         default: collect_garbage();
      endcase
      return r;
   endfunction

   // Driver: bursts of beats with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(apply_heap_cmd({req_cmd, req_first_ref, req_second_ref}));
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_cmds.size() > 0 && pending_cmds[0].cmd === 2'bxx) begin
               start <= 1'b0;
            end else if (pending_cmds.size() > 0 && !hold_until_drained) begin
               heap_cmd_t c;
               c = pending_cmds.pop_front();
               start <= 1'b1;
               req_cmd <= c.cmd;
               req_first_ref <= c.first_ref;
               req_second_ref <= c.second_ref;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 20);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected beat result_ref=%0d status=%0d",
                     $time, rsp_result_ref, rsp_status);
            fail_count++;
         end else begin
            heap_rsp_t e;
            e = expected_rsps.pop_front();
            if (rsp_result_ref !== e.result_ref) begin
               $display("%0t: result_ref expected %0d actual %0d",
                        $time, e.result_ref, rsp_result_ref);
               fail_count++;
            end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, e.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** mark_sweep_pair_heap: FAILED **");
         $finish;
      end
   end

   function automatic logic [REF_W-1:0] rand_ref();
      case ($urandom_range(0, 9))
         0: return NULL_REF;
         1: return REF_W'($urandom_range(257, 511));
         2, 3: return REF_W'($urandom_range(0, 15));
         default: return REF_W'($urandom_range(0, HEAP_CELLS - 1));
      endcase
   endfunction

   task automatic add_cmd(cmd_type c, logic [REF_W-1:0] a, logic [REF_W-1:0] b);
      pending_cmds.push_back({c, a, b});
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || start || busy || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int n;
      reset_heap_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pop, extremes, null and out-of-range references.
      add_cmd(CMD_POP, '0, '0);
      add_cmd(CMD_ALLOC, '0, '1);
      add_cmd(CMD_ALLOC, NULL_REF, 9'd255);
      add_cmd(CMD_ALLOC, 9'd255, NULL_REF);
      add_cmd(CMD_PUSH, 9'd1, '0);
      add_cmd(CMD_PUSH, '1, '0);
      add_cmd(CMD_PUSH, NULL_REF, '0);
      add_cmd(CMD_COLLECT, '0, '0);
      add_cmd(CMD_POP, '0, '0);
      add_cmd(CMD_POP, '0, '0);
      add_cmd(CMD_COLLECT, '1, '1);
      add_cmd(CMD_POP, '0, '0);
      add_cmd(CMD_COLLECT, '0, '0);
      wait_drained();

      // Fill the root stack past its depth, then the heap past its size.
      hold_until_drained = 1'b0;
      for (int i = 0; i < STACK_DEPTH + 2; i++) add_cmd(CMD_PUSH, REF_W'(i), '0);
      for (int i = 0; i < HEAP_CELLS + 2; i++)
         add_cmd(CMD_ALLOC, REF_W'((i + 1) % 300), REF_W'(i % 2 ? HEAP_CELLS : i + 2));
      add_cmd(CMD_COLLECT, '0, '0);
      for (int i = 0; i < STACK_DEPTH + 1; i++) add_cmd(CMD_POP, '0, '0);
      add_cmd(CMD_COLLECT, '0, '0);
      wait_drained();

      // Random phases, mostly allocations and root traffic with random collects.
      n = 0;
      while (n < 1550) begin
         for (int j = 0; j < 150 && n < 1550; j++, n++) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7: add_cmd(CMD_ALLOC, rand_ref(), rand_ref());
               8, 9, 10, 11, 12: add_cmd(CMD_PUSH, rand_ref(), REF_W'($urandom));
               13, 14, 15, 16: add_cmd(CMD_POP, REF_W'($urandom), REF_W'($urandom));
               default: add_cmd(CMD_COLLECT, REF_W'($urandom), REF_W'($urandom));
            endcase
         end
         wait_drained();
      end

      stimulus_done = 1'b1;
      wait_drained();
      repeat (2000) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("** mark_sweep_pair_heap: PASSED **");
      end else begin
         $display("** mark_sweep_pair_heap: FAILED **");
      end
      $finish;
   end

endmodule
